[design/scpd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package scpd_pkg;

    // Image limits
    localparam int unsigned MAX_WIDTH  = 2048;
    localparam int unsigned MAX_HEIGHT = 2048;

    localparam int unsigned COL_W = $clog2(MAX_WIDTH);
    localparam int unsigned ROW_W = $clog2(MAX_HEIGHT);

    // Fixed field widths
    localparam int unsigned DIM_W     = 12;
    localparam int unsigned PIX_W     = 8;
    localparam int unsigned COORD_W   = 11;
    localparam int unsigned RESULT_W  = 2 * COORD_W;
    localparam int unsigned TDATA_IN_W  = 8;
    localparam int unsigned TDATA_OUT_W = 24;

    // Configuration registers
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;
    localparam logic [DIM_W-1:0] IMAGE_WIDTH_RST  = 12'd640;
    localparam logic [DIM_W-1:0] IMAGE_HEIGHT_RST = 12'd480;
    localparam logic [DIM_W-1:0] DIM_MIN          = 12'd3;

    // Line store entry: bit 0 upper row, bit 1 middle row
    localparam int unsigned LS_W = 2;

    // Output queue
    localparam int unsigned OQ_DEPTH = 4;
    localparam int unsigned OQ_AW    = $clog2(OQ_DEPTH);
    localparam int unsigned OQ_CW    = OQ_AW + 1;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
    } scpd_pos_t;

    function automatic logic is_crossing(input logic [8:0] code);
        return code inside {
            9'd58,  9'd85,  9'd114, 9'd115, 9'd117, 9'd122, 9'd154, 9'd156,
            9'd157, 9'd158, 9'd177, 9'd178, 9'd179, 9'd181, 9'd184, 9'd185,
            9'd186, 9'd188, 9'd189, 9'd213, 9'd241, 9'd242, 9'd243, 9'd245,
            9'd277, 9'd282, 9'd285, 9'd286, 9'd314, 9'd337, 9'd339, 9'd340,
            9'd341, 9'd342, 9'd346, 9'd348, 9'd350, 9'd369, 9'd370, 9'd371,
            9'd378, 9'd405, 9'd410, 9'd412, 9'd413, 9'd414
        };
    endfunction

endpackage

`default_nettype wire

[design/scpd_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port RAM, registered read, read-first on address collision.
module scpd_ram #(
    parameter int unsigned WIDTH = 2,
    parameter int unsigned DEPTH = 2048
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[design/scpd_pos.sv]
`timescale 1ns / 1ps
`default_nettype none

// Config registers and raster position counters.
module scpd_pos (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [scpd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [scpd_pkg::DIM_W-1:0]     cfg_data,
    input  wire logic                           accept,
    input  wire logic                           frame_start,
    output scpd_pkg::scpd_pos_t                 pos
);

    logic [scpd_pkg::DIM_W-1:0] width_reg, width_next;
    logic [scpd_pkg::DIM_W-1:0] height_reg, height_next;
    logic [scpd_pkg::COL_W-1:0] col_reg, col_next;
    logic [scpd_pkg::ROW_W-1:0] row_reg, row_next;
    logic [31:0]                width_eff, height_eff;
    logic [31:0]                col_inc, row_inc;

    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                scpd_pkg::REG_IMAGE_WIDTH:  width_next  = cfg_data;
                scpd_pkg::REG_IMAGE_HEIGHT: height_next = cfg_data;
                default: ;
            endcase
        end
    end

    // clamp to 3..MAX
    always_comb
    begin
        if (width_reg < scpd_pkg::DIM_MIN)
            width_eff = 32'(scpd_pkg::DIM_MIN);
        else if (32'(width_reg) > 32'(scpd_pkg::MAX_WIDTH))
            width_eff = 32'(scpd_pkg::MAX_WIDTH);
        else
            width_eff = 32'(width_reg);

        if (height_reg < scpd_pkg::DIM_MIN)
            height_eff = 32'(scpd_pkg::DIM_MIN);
        else if (32'(height_reg) > 32'(scpd_pkg::MAX_HEIGHT))
            height_eff = 32'(scpd_pkg::MAX_HEIGHT);
        else
            height_eff = 32'(height_reg);
    end

    always_comb
    begin
        pos.col = frame_start ? '0 : col_reg;
        pos.row = frame_start ? '0 : row_reg;
        col_inc = 32'(pos.col) + 32'd1;
        row_inc = 32'(pos.row) + 32'd1;
        col_next = col_reg;
        row_next = row_reg;
        if (accept)
        begin
            if (col_inc >= width_eff)
            begin
                col_next = '0;
                row_next = (row_inc >= height_eff) ? '0 : scpd_pkg::ROW_W'(row_inc);
            end
            else
            begin
                col_next = scpd_pkg::COL_W'(col_inc);
                row_next = pos.row;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= scpd_pkg::IMAGE_WIDTH_RST;
            height_reg <= scpd_pkg::IMAGE_HEIGHT_RST;
            col_reg    <= '0;
            row_reg    <= '0;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
        end
    end

endmodule

`default_nettype wire

[design/scpd_outq.sv]
`timescale 1ns / 1ps
`default_nettype none

// Small result queue between the window stage and the output channel.
module scpd_outq (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push,
    input  wire logic [scpd_pkg::RESULT_W-1:0] push_data,
    input  wire logic                          pop_ready,
    output logic                               out_valid,
    output logic      [scpd_pkg::RESULT_W-1:0] out_data,
    output logic      [scpd_pkg::OQ_CW-1:0]    count
);

    logic [scpd_pkg::RESULT_W-1:0] slot_reg [scpd_pkg::OQ_DEPTH];
    logic [scpd_pkg::OQ_AW-1:0]    head_reg, head_next;
    logic [scpd_pkg::OQ_AW-1:0]    tail_reg, tail_next;
    logic [scpd_pkg::OQ_CW-1:0]    count_reg, count_next;
    logic                          pop;

    assign out_valid = (count_reg != '0);
    assign out_data  = slot_reg[head_reg];
    assign count     = count_reg;
    assign pop       = out_valid && pop_ready;

    always_comb
    begin
        head_next  = pop  ? head_reg + scpd_pkg::OQ_AW'(1) : head_reg;
        tail_next  = push ? tail_reg + scpd_pkg::OQ_AW'(1) : tail_reg;
        count_next = count_reg + scpd_pkg::OQ_CW'(push) - scpd_pkg::OQ_CW'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[tail_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

[design/skeleton_crossing_point_detector.sv]
`timescale 1ns / 1ps
`default_nettype none

// Skeleton crossing point detector. Feed a thinned binary image in raster
// order, one pixel per request on the s_ side (nonzero byte = skeleton);
// set s_tuser on the first pixel of every frame. For each interior pixel
// whose 3x3 neighbourhood code (top-left bit 0 .. bottom-right bit 8) is one
// of the 46 crossing codes, one request leaves on the m_ side carrying the
// centre's column and row. The block takes one pixel per clock while
// s_tready is high: the line store is a single two-bit-wide RAM (upper
// and middle rows) with one read and one write per clock, and the
// read-modify-write of a column is split between the read and the stage 1
// write-back, with a forwarding register for back-to-back hits on the same
// column (a frame start straight after a column-0 pixel). Stage 1 pushes
// each result into a four-entry output queue that absorbs back-pressure,
// and s_tready drops only when that queue could overflow. The line store
// has no reset and no clearing pass: start every frame with frame start.
// Write image_width (index 0) and image_height (index 1) only while idle;
// values are clamped to 3..2048.
module skeleton_crossing_point_detector (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // pixel input
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [scpd_pkg::TDATA_IN_W-1:0]  s_tdata,   // [7:0] pixel_value
    input  wire logic                             s_tuser,   // [0] frame_start
    // crossing point output
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic      [scpd_pkg::TDATA_OUT_W-1:0] m_tdata,   // [10:0] point_column,
                                                             // [21:11] point_row, zero pad
    // configuration write
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [scpd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [scpd_pkg::DIM_W-1:0]       cfg_data
);

    scpd_pkg::scpd_pos_t               pos;
    logic                              accept;
    logic                              cur_bit;

    // stage 1 (line store read data available)
    logic                              s1_valid_reg;
    scpd_pkg::scpd_pos_t               s1_pos_reg;
    logic                              s1_cur_reg;
    logic                              fwd_hit_reg, fwd_hit_next;
    logic [scpd_pkg::LS_W-1:0]         fwd_data_reg;
    logic [5:0]                        window_reg, window_next;

    logic [scpd_pkg::LS_W-1:0]         ram_rdata;
    logic [scpd_pkg::LS_W-1:0]         ld;
    logic [scpd_pkg::LS_W-1:0]         wdata;
    logic [2:0]                        newcol;
    logic [8:0]                        code;
    logic                              hit;
    logic [scpd_pkg::COL_W-1:0]        col_m1;
    logic [scpd_pkg::ROW_W-1:0]        row_m1;
    logic [scpd_pkg::RESULT_W-1:0]     result;

    logic [scpd_pkg::RESULT_W-1:0]     q_data;
    logic [scpd_pkg::OQ_CW-1:0]        q_count;

    assign cfg_ready = 1'b1;

    // room for the item in stage 1 and the one taken now
    assign s_tready = (q_count + scpd_pkg::OQ_CW'(s1_valid_reg))
                      <= scpd_pkg::OQ_CW'(scpd_pkg::OQ_DEPTH - 1);
    assign accept   = s_tvalid && s_tready;
    assign cur_bit  = (s_tdata[scpd_pkg::PIX_W-1:0] != '0);

    scpd_pos u_pos (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .accept      (accept),
        .frame_start (s_tuser),
        .pos         (pos)
    );

    // line store: bit 0 row r-2, bit 1 row r-1
    scpd_ram #(
        .WIDTH (scpd_pkg::LS_W),
        .DEPTH (scpd_pkg::MAX_WIDTH)
    ) u_line_store (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_pos_reg.col),
        .wdata (wdata),
        .raddr (pos.col),
        .rdata (ram_rdata)
    );

    // window stage: build code, write the column back, shift window
    always_comb
    begin
        ld     = fwd_hit_reg ? fwd_data_reg : ram_rdata;
        newcol = {s1_cur_reg, ld[1], ld[0]};
        wdata  = {s1_cur_reg, ld[1]};

        code[0] = window_reg[3];
        code[3] = window_reg[4];
        code[6] = window_reg[5];
        code[1] = window_reg[0];
        code[4] = window_reg[1];
        code[7] = window_reg[2];
        code[2] = newcol[0];
        code[5] = newcol[1];
        code[8] = newcol[2];

        hit = s1_valid_reg
              && (s1_pos_reg.col >= scpd_pkg::COL_W'(2))
              && (s1_pos_reg.row >= scpd_pkg::ROW_W'(2))
              && code[4]
              && scpd_pkg::is_crossing(code);

        col_m1 = s1_pos_reg.col - scpd_pkg::COL_W'(1);
        row_m1 = s1_pos_reg.row - scpd_pkg::ROW_W'(1);
        result = {scpd_pkg::COORD_W'(row_m1), scpd_pkg::COORD_W'(col_m1)};

        window_next  = s1_valid_reg ? {window_reg[2:0], newcol} : window_reg;
        // read issued now hits the column being written this cycle
        fwd_hit_next = accept && s1_valid_reg && (pos.col == s1_pos_reg.col);
    end

    always_ff @(posedge clk)
    begin
        s1_pos_reg   <= pos;
        s1_cur_reg   <= cur_bit;
        fwd_data_reg <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
            window_reg   <= '0;
        end
        else
        begin
            s1_valid_reg <= accept;
            fwd_hit_reg  <= fwd_hit_next;
            window_reg   <= window_next;
        end
    end

    scpd_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (hit),
        .push_data (result),
        .pop_ready (m_tready),
        .out_valid (m_tvalid),
        .out_data  (q_data),
        .count     (q_count)
    );

    assign m_tdata = {(scpd_pkg::TDATA_OUT_W - scpd_pkg::RESULT_W)'(0), q_data};

endmodule

`default_nettype wire

[design/scpd_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module scpd_checker (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             s_tvalid,
    input wire logic                             s_tready,
    input wire logic                             m_tvalid,
    input wire logic                             m_tready,
    input wire logic [scpd_pkg::TDATA_OUT_W-1:0] m_tdata
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // a new result traces back to an accepted pixel, via stage 1 and the queue
    a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result without a pixel two clocks earlier");

    // centres are interior, padding is zero
    a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[10:0] != 11'd0) && (m_tdata[21:11] != 11'd0)
                     && (m_tdata[23:22] == 2'b00))
        else $error("result coordinate out of range");

    // empty output side never blocks input
    a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

endmodule

bind skeleton_crossing_point_detector scpd_checker u_scpd_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
